// ----- sv/flob_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// flob_pkg
// Shared types and constants for the five-level order book core.
// ----------------------------------------------------------------------------
package flob_pkg;

    localparam int NumSymbols = 64;
    localparam int BookLevels = 5;
    localparam int SymbolBits = 64;
    localparam int SlotW      = $clog2(NumSymbols);
    localparam int LvlW       = $clog2(BookLevels);

    localparam logic [1:0] KIND_SNAP   = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    localparam logic [1:0] SIDE_BID = 2'd1;
    localparam logic [1:0] SIDE_ASK = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_BADLEVEL = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_CLEAR,
        S_READ,
        S_LOAD,
        S_WRITE,
        S_QUERY,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ----- sv/five_level_order_book_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// five_level_order_book_core
// Per-symbol five-level bid/ask book held in one synchronous level memory.
// ----------------------------------------------------------------------------
// A request is taken only while the core is idle. Symbol lookup walks the
// 64-entry key memory one entry per cycle and stops at the first match. A
// snapshot item that is not the first of its message skips the lookup. A
// snapshot first item then clears the ten levels of its new entry and writes
// its own level. Update and delete run the lookup, then a decision step, five
// level reads plus a drain step, and five level writes. A query runs the
// lookup and a decision step, then a read and an output step for each of its
// ten results. One output register holds each result; while it is occupied
// and i_stall is high, the core waits in place.
module five_level_order_book_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_symbol,
    input  wire logic [1:0]  i_side,
    input  wire logic [2:0]  i_level,
    input  wire logic [63:0] i_price,
    input  wire logic [31:0] i_quantity,
    input  wire logic        i_snapshot_first,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [1:0]       o_out_side,
    output logic [2:0]       o_out_level,
    output logic [63:0]      o_out_price,
    output logic [31:0]      o_out_quantity,
    output logic             o_last
);

    localparam int NS   = flob_pkg::NumSymbols;
    localparam int BL   = flob_pkg::BookLevels;
    localparam int SW   = flob_pkg::SlotW;
    localparam int LW   = flob_pkg::LvlW;
    localparam int LD   = NS * 2 * BL;
    localparam int AW   = $clog2(LD);
    localparam int IW   = $clog2(2 * BL + 1);

    // key memory and level memory (word = {price, size})
    logic [flob_pkg::SymbolBits-1:0] key_mem [NS];
    logic [95:0]                     lvl_mem [LD];
    logic [NS-1:0]                   r_valid_bits;

    logic [SW-1:0] key_raddr;
    logic [flob_pkg::SymbolBits-1:0] key_rdata;
    logic          key_we;
    logic [SW-1:0] key_waddr;
    logic [AW-1:0] lvl_raddr, lvl_waddr;
    logic [95:0]   lvl_rdata, lvl_wdata;
    logic          lvl_we;

    flob_pkg::t_state r_state, n_state;
    logic [1:0]  r_kind;
    logic [flob_pkg::SymbolBits-1:0] r_key;
    logic [1:0]  r_side;
    logic [2:0]  r_level;
    logic [63:0] r_price;
    logic [31:0] r_qty;
    logic        r_first;
    logic [SW:0] r_scan;      // scan index, top bit = past end
    logic        r_scan_rd;   // a key read is in flight
    logic [SW-1:0] r_scan_prev;
    logic        r_found;
    logic [SW-1:0] r_slot;
    logic [IW-1:0] r_idx;
    logic          r_rd_pend;
    logic [63:0] r_pr [BL];
    logic [31:0] r_sz [BL];
    logic        r_drop;
    logic [SW-1:0] r_snap_slot;

    logic          r_ovalid;
    logic [2:0]    r_ostatus;
    logic [1:0]    r_oside;
    logic [2:0]    r_olevel;
    logic [63:0]   r_oprice;
    logic [31:0]   r_oqty;
    logic          r_olast;

    always_ff @(posedge i_clk) begin
        key_rdata <= key_mem[key_raddr];
        if (key_we) begin
            key_mem[key_waddr] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        lvl_rdata <= lvl_mem[lvl_raddr];
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
    end

    logic in_acc, out_free;
    assign o_stall  = (r_state != flob_pkg::S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    logic [flob_pkg::SymbolBits-1:0] in_key;
    assign in_key = i_symbol[flob_pkg::SymbolBits-1:0];

    logic lvl_ok;
    assign lvl_ok = (r_side == flob_pkg::SIDE_BID || r_side == flob_pkg::SIDE_ASK)
        && r_level >= 3'd1 && r_level <= 3'(BL);

    logic side_ask;
    assign side_ask = (r_side == flob_pkg::SIDE_ASK);

    function automatic logic [AW-1:0] lvl_addr(input logic [SW-1:0] slot,
                                               input logic ask,
                                               input logic [LW-1:0] lv);
        logic [AW+1:0] a;
        a = (AW+2)'(slot) * (AW+2)'(2 * BL) + (ask ? (AW+2)'(BL) : '0) + (AW+2)'(lv);
        return a[AW-1:0];
    endfunction

    logic [SW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!r_valid_bits[i]) begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    // output request emission helper signals
    logic        emit;
    logic [2:0]  emit_st;
    logic [1:0]  emit_side;
    logic [2:0]  emit_lvl;
    logic [63:0] emit_pr;
    logic [31:0] emit_sz;
    logic        emit_last;

    // packed side after update or delete
    logic [63:0] pk_pr [BL];
    logic [31:0] pk_sz [BL];
    logic [63:0] wk_pr [BL];
    logic [31:0] wk_sz [BL];
    always_comb begin
        logic [LW:0] n;
        for (int i = 0; i < BL; i++) begin
            wk_pr[i] = r_pr[i];
            wk_sz[i] = r_sz[i];
        end
        if (r_kind == flob_pkg::KIND_UPDATE) begin
            wk_pr[r_level - 3'd1] = r_price;
            wk_sz[r_level - 3'd1] = r_qty;
        end
        n = '0;
        for (int i = 0; i < BL; i++) begin
            pk_pr[i] = '0;
            pk_sz[i] = '0;
        end
        for (int i = 0; i < BL; i++) begin
            if (wk_sz[i] != 32'd0) begin
                pk_pr[n[LW-1:0]] = wk_pr[i];
                pk_sz[n[LW-1:0]] = wk_sz[i];
                n = n + 1'b1;
            end
        end
        for (int i = 0; i < BL; i++) begin
            if (wk_sz[i] == 32'd0) begin
                pk_pr[n[LW-1:0]] = wk_pr[i];
                pk_sz[n[LW-1:0]] = 32'd0;
                n = n + 1'b1;
            end
        end
        if (r_kind == flob_pkg::KIND_DELETE) begin
            for (int i = 0; i < BL; i++) begin
                if (i + 1 >= int'(r_level) && i < BL - 1) begin
                    pk_pr[i] = r_pr[i + 1];
                    pk_sz[i] = r_sz[i + 1];
                end else begin
                    pk_pr[i] = r_pr[i];
                    pk_sz[i] = r_sz[i];
                end
            end
            pk_pr[BL - 1] = '0;
            pk_sz[BL - 1] = '0;
        end
    end

    logic [LW-1:0] idx_lv;
    logic          idx_ask;
    assign idx_ask = (r_idx >= IW'(BL));
    assign idx_lv  = idx_ask ? LW'(r_idx - IW'(BL)) : LW'(r_idx);

    logic n_found_set, n_drop_set, n_drop_clr, valid_set, snap_set;
    logic [SW-1:0] n_slot_v;

    always_comb begin
        n_state   = r_state;
        key_raddr = r_scan[SW-1:0];
        key_we    = 1'b0;
        key_waddr = free_idx[SW-1:0];
        lvl_raddr = lvl_addr(r_slot, idx_ask, idx_lv);
        lvl_waddr = lvl_addr(r_slot, idx_ask, idx_lv);
        lvl_wdata = '0;
        lvl_we    = 1'b0;
        emit      = 1'b0;
        emit_st   = flob_pkg::ST_OK;
        emit_side = '0;
        emit_lvl  = '0;
        emit_pr   = '0;
        emit_sz   = '0;
        emit_last = 1'b1;
        valid_set = 1'b0;
        n_drop_set = 1'b0;
        n_drop_clr = 1'b0;
        snap_set  = 1'b0;
        n_found_set = 1'b0;
        n_slot_v  = r_slot;
        case (r_state)
            flob_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_kind == flob_pkg::KIND_SNAP && !i_snapshot_first) begin
                        n_state = flob_pkg::S_DECIDE;
                    end else begin
                        n_state = flob_pkg::S_SCAN;
                    end
                end
            end
            flob_pkg::S_SCAN: begin
                if (r_scan_rd && r_valid_bits[r_scan_prev] && key_rdata == r_key) begin
                    n_found_set = 1'b1;
                    n_slot_v    = r_scan_prev;
                    n_state     = flob_pkg::S_DECIDE;
                end else if (r_scan[SW] && !r_scan_rd) begin
                    n_state = flob_pkg::S_DECIDE;
                end
            end
            flob_pkg::S_DECIDE: begin
                if (out_free) begin
                    n_state = flob_pkg::S_IDLE;
                    emit    = 1'b1;
                    if (r_kind == flob_pkg::KIND_SNAP) begin
                        if (r_first) begin
                            if (r_found) begin
                                n_drop_set = 1'b1;
                                emit_st = flob_pkg::ST_DUP;
                            end else if (!free_any) begin
                                n_drop_set = 1'b1;
                                emit_st = flob_pkg::ST_FULL;
                            end else begin
                                emit      = 1'b0;
                                valid_set = 1'b1;
                                key_we    = 1'b1;
                                n_drop_clr = 1'b1;
                                snap_set  = 1'b1;
                                n_slot_v  = free_idx[SW-1:0];
                                n_state   = flob_pkg::S_CLEAR;
                            end
                        end else if (r_drop) begin
                            emit_st = flob_pkg::ST_DUP;
                        end else begin
                            emit      = 1'b0;
                            n_slot_v  = r_snap_slot;
                            key_raddr = r_snap_slot;
                            n_state   = flob_pkg::S_LOAD;
                        end
                    end else if (!r_found) begin
                        emit_st = flob_pkg::ST_UNKNOWN;
                    end else if (r_kind == flob_pkg::KIND_QUERY) begin
                        emit    = 1'b0;
                        n_state = flob_pkg::S_QUERY;
                    end else if (!lvl_ok) begin
                        emit_st = flob_pkg::ST_BADLEVEL;
                    end else begin
                        emit    = 1'b0;
                        n_state = flob_pkg::S_READ;
                    end
                end
            end
            flob_pkg::S_CLEAR: begin
                lvl_we = 1'b1;
                if (r_idx == IW'(2 * BL - 1)) begin
                    n_state = flob_pkg::S_WRITE;
                end
            end
            flob_pkg::S_LOAD: begin
                // key of current snapshot slot is on key_rdata; hold the read
                key_raddr = r_slot;
                if (out_free) begin
                    if (!r_valid_bits[r_slot] || key_rdata != r_key) begin
                        emit    = 1'b1;
                        emit_st = flob_pkg::ST_UNKNOWN;
                        n_state = flob_pkg::S_IDLE;
                    end else begin
                        n_state = flob_pkg::S_WRITE;
                    end
                end
            end
            flob_pkg::S_READ: begin
                lvl_raddr = lvl_addr(r_slot, side_ask, idx_lv);
                lvl_waddr = lvl_addr(r_slot, side_ask, idx_lv);
                if (r_idx == IW'(BL) && !r_rd_pend) begin
                    lvl_we    = 1'b1;
                    lvl_wdata = {pk_pr[0], pk_sz[0]};
                    lvl_waddr = lvl_addr(r_slot, side_ask, '0);
                    n_state   = flob_pkg::S_WRITE;
                end
            end
            flob_pkg::S_WRITE: begin
                if (r_kind == flob_pkg::KIND_SNAP) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = flob_pkg::S_IDLE;
                        if (!lvl_ok) begin
                            emit_st = flob_pkg::ST_BADLEVEL;
                        end else begin
                            lvl_we    = 1'b1;
                            lvl_waddr = lvl_addr(r_slot, side_ask, LW'(r_level - 3'd1));
                            lvl_wdata = {r_price, r_qty};
                        end
                    end
                end else begin
                    lvl_we    = 1'b1;
                    lvl_waddr = lvl_addr(r_slot, side_ask, idx_lv);
                    lvl_wdata = {pk_pr[idx_lv], pk_sz[idx_lv]};
                    if (r_idx == IW'(BL - 1)) begin
                        lvl_we  = out_free;
                        emit    = out_free;
                        n_state = out_free ? flob_pkg::S_IDLE : flob_pkg::S_WRITE;
                    end
                end
            end
            flob_pkg::S_QUERY: begin
                lvl_raddr = lvl_addr(r_slot, idx_ask, idx_lv);
                n_state   = flob_pkg::S_OUT;
            end
            flob_pkg::S_OUT: begin
                lvl_raddr = lvl_addr(r_slot, idx_ask, idx_lv);
                if (out_free) begin
                    emit      = 1'b1;
                    emit_side = (r_idx >= IW'(BL)) ? flob_pkg::SIDE_ASK : flob_pkg::SIDE_BID;
                    emit_lvl  = (r_idx >= IW'(BL)) ? 3'(r_idx - IW'(BL) + 1'b1)
                                                  : 3'(r_idx + 1'b1);
                    emit_pr   = lvl_rdata[95:32];
                    emit_sz   = lvl_rdata[31:0];
                    emit_last = (r_idx == IW'(2 * BL - 1));
                    n_state   = emit_last ? flob_pkg::S_IDLE : flob_pkg::S_QUERY;
                end
            end
            default: n_state = flob_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flob_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits <= '0;
            r_drop       <= 1'b0;
            r_snap_slot  <= '0;
            r_ovalid     <= 1'b0;
            r_scan_rd    <= 1'b0;
            r_rd_pend    <= 1'b0;
        end else begin
            if (valid_set) begin
                r_valid_bits[free_idx[SW-1:0]] <= 1'b1;
            end
            if (n_drop_set) begin
                r_drop <= 1'b1;
            end
            if (n_drop_clr) begin
                r_drop <= 1'b0;
            end
            if (snap_set) begin
                r_snap_slot <= free_idx[SW-1:0];
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_scan_rd <= (r_state == flob_pkg::S_SCAN) && !r_scan[SW] && !n_found_set;
            r_rd_pend <= (r_state == flob_pkg::S_READ) && (r_idx < IW'(BL));
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot_v;
        if (in_acc) begin
            r_kind  <= i_kind;
            r_key   <= in_key;
            r_side  <= i_side;
            r_level <= i_level;
            r_price <= i_price;
            r_qty   <= i_quantity;
            r_first <= i_snapshot_first;
            r_scan  <= '0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end
        if (r_state == flob_pkg::S_SCAN) begin
            if (!r_scan[SW]) begin
                r_scan <= r_scan + 1'b1;
            end
            r_scan_prev <= r_scan[SW-1:0];
            if (n_found_set) begin
                r_found <= 1'b1;
            end
        end
        if (r_state == flob_pkg::S_DECIDE) begin
            r_idx <= '0;
        end
        if (r_state == flob_pkg::S_CLEAR) begin
            r_idx <= (r_idx == IW'(2 * BL - 1)) ? '0 : r_idx + 1'b1;
        end
        if (r_state == flob_pkg::S_READ) begin
            if (r_rd_pend) begin
                r_pr[LW'(r_idx - 1'b1)] <= lvl_rdata[95:32];
                r_sz[LW'(r_idx - 1'b1)] <= lvl_rdata[31:0];
            end
            if (r_idx < IW'(BL)) begin
                r_idx <= r_idx + 1'b1;
            end else if (!r_rd_pend) begin
                r_idx <= IW'(1);
            end
        end
        if (r_state == flob_pkg::S_WRITE && r_kind != flob_pkg::KIND_SNAP
            && r_idx != IW'(BL - 1)) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == flob_pkg::S_OUT && out_free) begin
            r_idx <= r_idx + 1'b1;
        end
        if (emit) begin
            r_ostatus <= emit_st;
            r_oside   <= emit_side;
            r_olevel  <= emit_lvl;
            r_oprice  <= emit_pr;
            r_oqty    <= emit_sz;
            r_olast   <= emit_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_out_side     = r_oside;
    assign o_out_level    = r_olevel;
    assign o_out_price    = r_oprice;
    assign o_out_quantity = r_oqty;
    assign o_last         = r_olast;

    ap_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != flob_pkg::S_IDLE) |-> !in_acc)
        else $error("request accepted while busy");
    ap_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result overwritten");
    ap_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        valid_set |-> !r_valid_bits[free_idx[SW-1:0]])
        else $error("allocated a live entry");

endmodule
`default_nettype wire

// ----- test/five_level_order_book_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_level_order_book_core_tb
// Self-checking bench for the order book core. A directed pass loads,
// updates, deletes and queries books and hits every status code but FULL. A random
// pass runs snapshot messages, updates, deletes, queries and noise on a small
// symbol pool, and a final pass fills the symbol table. Both channels idle at
// random, and the result side holds off once for a long stretch. A
// scoreboard predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module five_level_order_book_core_tb;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  side;
        logic [2:0]  level;
        logic [63:0] price;
        logic [31:0] qty;
        logic        last;
    } t_book_result;

    class t_book_scoreboard;
        logic [63:0]  keys [flob_pkg::NumSymbols];
        bit           live [flob_pkg::NumSymbols];
        logic [63:0]  px [2][flob_pkg::NumSymbols][flob_pkg::BookLevels];
        logic [31:0]  sz [2][flob_pkg::NumSymbols][flob_pkg::BookLevels];
        bit           dropping;
        int           snap_slot;
        t_book_result pending_q[$];
        int           errors;
        int           checked;

        function new();
            foreach (live[i]) live[i] = 0;
            dropping = 0;
            snap_slot = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int lookup(logic [63:0] key);
            for (int i = 0; i < flob_pkg::NumSymbols; i++)
                if (live[i] && keys[i] == key) return i;
            return -1;
        endfunction

        function void push_status(logic [2:0] st);
            t_book_result r;
            r = '0;
            r.status = st;
            r.last = 1'b1;
            pending_q.push_back(r);
        endfunction

        function bit level_good(logic [1:0] side, logic [2:0] lvl);
            return (side == flob_pkg::SIDE_BID || side == flob_pkg::SIDE_ASK)
                && lvl >= 3'd1 && lvl <= 3'(flob_pkg::BookLevels);
        endfunction

        function void note_request(logic [1:0] kind, logic [63:0] key, logic [1:0] side,
                                   logic [2:0] lvl, logic [63:0] price, logic [31:0] qty,
                                   logic first);
            int slot;
            int s;
            int n;
            logic [63:0] np [flob_pkg::BookLevels];
            logic [31:0] ns [flob_pkg::BookLevels];
            t_book_result r;
            s = (side == flob_pkg::SIDE_BID) ? 0 : 1;
            if (kind == flob_pkg::KIND_SNAP) begin
                if (first) begin
                    if (lookup(key) >= 0) begin
                        dropping = 1;
                        push_status(flob_pkg::ST_DUP);
                        return;
                    end
                    slot = -1;
                    for (int i = 0; i < flob_pkg::NumSymbols; i++)
                        if (!live[i]) begin
                            slot = i;
                            break;
                        end
                    if (slot < 0) begin
                        dropping = 1;
                        push_status(flob_pkg::ST_FULL);
                        return;
                    end
                    live[slot] = 1;
                    keys[slot] = key;
                    for (int j = 0; j < 2; j++)
                        for (int l = 0; l < flob_pkg::BookLevels; l++) begin
                            px[j][slot][l] = '0;
                            sz[j][slot][l] = '0;
                        end
                    snap_slot = slot;
                    dropping = 0;
                end else begin
                    if (dropping) begin
                        push_status(flob_pkg::ST_DUP);
                        return;
                    end
                    slot = snap_slot;
                    if (!live[slot] || keys[slot] != key) begin
                        push_status(flob_pkg::ST_UNKNOWN);
                        return;
                    end
                end
                if (!level_good(side, lvl)) begin
                    push_status(flob_pkg::ST_BADLEVEL);
                    return;
                end
                px[s][slot][lvl-1] = price;
                sz[s][slot][lvl-1] = qty;
                push_status(flob_pkg::ST_OK);
                return;
            end
            slot = lookup(key);
            if (slot < 0) begin
                push_status(flob_pkg::ST_UNKNOWN);
                return;
            end
            if (kind == flob_pkg::KIND_QUERY) begin
                for (int i = 0; i < 2 * flob_pkg::BookLevels; i++) begin
                    r.status = flob_pkg::ST_OK;
                    r.side = (i < flob_pkg::BookLevels) ? flob_pkg::SIDE_BID
                                                        : flob_pkg::SIDE_ASK;
                    r.level = 3'((i % flob_pkg::BookLevels) + 1);
                    r.price = px[i / flob_pkg::BookLevels][slot][i % flob_pkg::BookLevels];
                    r.qty = sz[i / flob_pkg::BookLevels][slot][i % flob_pkg::BookLevels];
                    r.last = (i == 2 * flob_pkg::BookLevels - 1);
                    pending_q.push_back(r);
                end
                return;
            end
            if (!level_good(side, lvl)) begin
                push_status(flob_pkg::ST_BADLEVEL);
                return;
            end
            if (kind == flob_pkg::KIND_UPDATE) begin
                px[s][slot][lvl-1] = price;
                sz[s][slot][lvl-1] = qty;
                n = 0;
                for (int i = 0; i < flob_pkg::BookLevels; i++)
                    if (sz[s][slot][i] != 0) begin
                        np[n] = px[s][slot][i];
                        ns[n] = sz[s][slot][i];
                        n++;
                    end
                for (int i = 0; i < flob_pkg::BookLevels; i++)
                    if (sz[s][slot][i] == 0) begin
                        np[n] = px[s][slot][i];
                        ns[n] = '0;
                        n++;
                    end
                for (int i = 0; i < flob_pkg::BookLevels; i++) begin
                    px[s][slot][i] = np[i];
                    sz[s][slot][i] = ns[i];
                end
            end else begin
                for (int i = int'(lvl); i < flob_pkg::BookLevels; i++) begin
                    px[s][slot][i-1] = px[s][slot][i];
                    sz[s][slot][i-1] = sz[s][slot][i];
                end
                px[s][slot][flob_pkg::BookLevels-1] = '0;
                sz[s][slot][flob_pkg::BookLevels-1] = '0;
            end
            push_status(flob_pkg::ST_OK);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(t_book_result got);
            t_book_result want;
            checked++;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending_q.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d want %0d", got.status, want.status));
            if (got.side != want.side)
                report($sformatf("side %0d want %0d", got.side, want.side));
            if (got.level != want.level)
                report($sformatf("level %0d want %0d", got.level, want.level));
            if (got.price != want.price)
                report($sformatf("price %h want %h", got.price, want.price));
            if (got.qty != want.qty)
                report($sformatf("quantity %0d want %0d", got.qty, want.qty));
            if (got.last != want.last)
                report($sformatf("last %0b want %0b", got.last, want.last));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_kind = '0;
    logic [63:0] i_symbol = '0;
    logic [1:0]  i_side = '0;
    logic [2:0]  i_level = '0;
    logic [63:0] i_price = '0;
    logic [31:0] i_quantity = '0;
    logic        i_snapshot_first = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [2:0]  o_status;
    logic [1:0]  o_out_side;
    logic [2:0]  o_out_level;
    logic [63:0] o_out_price;
    logic [31:0] o_out_quantity;
    logic        o_last;

    t_book_scoreboard sb = new();
    logic [63:0] sym_pool [12];
    int          hold_left = 0;
    bit          long_hold_done = 0;
    int          cyc = 0;

    five_level_order_book_core uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (o_valid && !i_stall)
            sb.check_result({o_status, o_out_side, o_out_level, o_out_price,
                             o_out_quantity, o_last});
    end

    // Result-side backpressure, with one long hold-off.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (!long_hold_done && sb.checked >= 40) begin
            long_hold_done <= 1'b1;
            hold_left <= 400;
            i_stall <= 1'b1;
        end else if ((cyc / 1500) % 3 == 0) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_qty();
        return ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
    endfunction

    task automatic send(logic [1:0] kind, logic [63:0] key, logic [1:0] side,
                        logic [2:0] lvl, logic [63:0] price, logic [31:0] qty,
                        logic first);
        int gap;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_symbol <= key;
        i_side <= side;
        i_level <= lvl;
        i_price <= price;
        i_quantity <= qty;
        i_snapshot_first <= first;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(kind, key, side, lvl, price, qty, first);
        @(negedge i_clk);
        if ((cyc / 1100) % 3 == 0) gap = 0;
        else if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 120);
        else if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 4);
        else gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic snapshot_message(logic [63:0] key, bit noisy);
        send(flob_pkg::KIND_SNAP, key, 2'($urandom_range(1, 2)), 3'($urandom_range(1, 5)),
             rand64(), rand_qty(), 1'b1);
        for (int i = 1; i < 2 * flob_pkg::BookLevels; i++) begin
            if (noisy && $urandom_range(0, 5) == 0)
                send(flob_pkg::KIND_SNAP, ($urandom_range(0, 1) ? rand64() : key),
                     2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand64(),
                     rand_qty(), 1'b0);
            else
                send(flob_pkg::KIND_SNAP, key,
                     (i < flob_pkg::BookLevels) ? flob_pkg::SIDE_BID : flob_pkg::SIDE_ASK,
                     3'((i % flob_pkg::BookLevels) + 1), rand64(), rand_qty(), 1'b0);
        end
    endtask

    initial begin
        logic [63:0] ka;
        logic [63:0] kb;
        int items;
        int pick;
        logic [63:0] key;
        foreach (sym_pool[i]) sym_pool[i] = rand64();
        sym_pool[0] = '0;
        sym_pool[1] = '1;
        ka = rand64();
        kb = rand64();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_BID, 3'd1, '1, '1, 1'b1);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_BID, 3'd2, '0, 32'd7, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_BID, 3'd3, rand64(), 32'd0, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_BID, 3'd4, rand64(), 32'd9, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_ASK, 3'd1, rand64(), 32'd1, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_ASK, 3'd5, rand64(), 32'd5, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, 2'd3, 3'd2, rand64(), 32'd3, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_ASK, 3'd0, rand64(), 32'd3, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_BID, 3'd7, rand64(), 32'd3, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_ASK, 3'd3, rand64(), '1, 1'b0);
        send(flob_pkg::KIND_QUERY, ka, 2'd0, 3'd0, '0, '0, 1'b0);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_BID, 3'd1, rand64(), 32'd2, 1'b1);
        send(flob_pkg::KIND_SNAP, ka, flob_pkg::SIDE_BID, 3'd1, rand64(), 32'd2, 1'b0);
        send(flob_pkg::KIND_SNAP, kb, 2'd0, 3'd1, rand64(), 32'd2, 1'b1);
        send(flob_pkg::KIND_SNAP, rand64(), flob_pkg::SIDE_BID, 3'd1, rand64(), 32'd2, 1'b0);
        send(flob_pkg::KIND_UPDATE, ka, flob_pkg::SIDE_BID, 3'd2, rand64(), 32'd0, 1'b0);
        send(flob_pkg::KIND_UPDATE, rand64(), flob_pkg::SIDE_BID, 3'd1, rand64(), 32'd4,
             1'b0);
        send(flob_pkg::KIND_UPDATE, ka, flob_pkg::SIDE_ASK, 3'd6, rand64(), 32'd4, 1'b1);
        send(flob_pkg::KIND_DELETE, ka, flob_pkg::SIDE_ASK, 3'd5, '0, '0, 1'b0);
        send(flob_pkg::KIND_DELETE, ka, flob_pkg::SIDE_BID, 3'd1, '0, '0, 1'b0);
        send(flob_pkg::KIND_DELETE, ka, 2'd3, 3'd1, '0, '0, 1'b0);
        send(flob_pkg::KIND_QUERY, ka, 2'd0, 3'd0, '0, '0, 1'b0);
        send(flob_pkg::KIND_QUERY, rand64(), 2'd0, 3'd0, '0, '0, 1'b0);
        send(flob_pkg::KIND_QUERY, kb, 2'd0, 3'd0, '0, '0, 1'b0);

        items = 0;
        while (items < 120) begin
            key = sym_pool[$urandom_range(0, 11)];
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                snapshot_message(key, $urandom_range(0, 2) == 0);
                items += 2 * flob_pkg::BookLevels;
            end else begin
                if (pick < 45)
                    send(flob_pkg::KIND_UPDATE, key, 2'($urandom_range(1, 2)),
                         3'($urandom_range(1, 5)), rand64(), rand_qty(),
                         1'($urandom_range(0, 1)));
                else if (pick < 62)
                    send(flob_pkg::KIND_DELETE, key, 2'($urandom_range(1, 2)),
                         3'($urandom_range(1, 5)), rand64(), rand_qty(),
                         1'($urandom_range(0, 1)));
                else if (pick < 85)
                    send(flob_pkg::KIND_QUERY, key, 2'($urandom_range(0, 3)),
                         3'($urandom_range(0, 7)), rand64(), rand_qty(),
                         1'($urandom_range(0, 1)));
                else
                    send(2'($urandom_range(0, 3)), ($urandom_range(0, 1) ? rand64() : key),
                         2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand64(),
                         $urandom, 1'($urandom_range(0, 1)));
                items++;
            end
        end

        // Fill the symbol table, then overflow it.
        for (int i = 0; i < flob_pkg::NumSymbols; i++)
            send(flob_pkg::KIND_SNAP, rand64(), 2'($urandom_range(1, 2)),
                 3'($urandom_range(1, 5)), rand64(), rand_qty(), 1'b1);
        send(flob_pkg::KIND_SNAP, rand64(), flob_pkg::SIDE_BID, 3'd1, rand64(), 32'd1, 1'b0);
        send(flob_pkg::KIND_QUERY, sym_pool[2], 2'd0, 3'd0, '0, '0, 1'b0);
        send(flob_pkg::KIND_UPDATE, ka, flob_pkg::SIDE_ASK, 3'd1, rand64(), rand_qty(), 1'b0);
        send(flob_pkg::KIND_QUERY, ka, 2'd0, 3'd0, '0, '0, 1'b0);
        i_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/flob_pkg.sv
sv/five_level_order_book_core.sv
test/five_level_order_book_core_tb.sv
